// File: sv/ssu16_pkg.sv
// ----------------------------------------------------------------------------
// ssu16_pkg
// shared widths, defaults and control bundles of the shell sort block
// ----------------------------------------------------------------------------
`default_nettype none

package ssu16_pkg;

  localparam int unsigned DataW       = 16;
  localparam int unsigned MaxItemsDef = 64;

  // memory port controls from the sequencer
  typedef struct packed {
    logic rd_en;
    logic wr_en;
  } mem_ctl_t;

  // output register controls from the sequencer
  typedef struct packed {
    logic load;
    logic last;
    logic ovf;
  } out_ctl_t;

endpackage

`default_nettype wire

// File: sv/ssu16_if.sv
// ----------------------------------------------------------------------------
// ssu16_if
// valid/ready channels of the shell sort block, input and result side
// ----------------------------------------------------------------------------
`default_nettype none

interface ssu16_in_if import ssu16_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [DataW-1:0] value;
  logic             is_final;

  modport source (output valid, output value, output is_final, input ready);
  modport sink   (input valid, input value, input is_final, output ready);
endinterface

interface ssu16_out_if import ssu16_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [DataW-1:0] sorted_value;
  logic             end_of_run;
  logic             overflow;

  modport source (output valid, output sorted_value, output end_of_run,
                  output overflow, input ready);
  modport sink   (input valid, input sorted_value, input end_of_run,
                  input overflow, output ready);
endinterface

`default_nettype wire

// File: sv/shell_sort_u16_core.sv
// ----------------------------------------------------------------------------
// shell_sort_u16_core
// gathers a run of unsigned 16-bit words and returns them in ascending order
// ----------------------------------------------------------------------------
// usage:
//   in_if carries one word per handshake; is_final closes the run. words are
//   stored one per cycle into an on-chip store of MAX_ITEMS entries; words
//   beyond capacity are dropped and overflow is set on every result of that
//   run. a final word that does not fit still starts the sort.
//   after the final word the block sorts in place by shell sort (gap n/2,
//   halving each pass, gapped insertion by swaps). every compare takes a read
//   of both entries and then a compare; a swap adds a write of each entry in
//   turn, since the store has a single write port. results leave on out_if,
//   smallest first, end_of_run on the largest; each result passes through a
//   store read, a register load and a handshake. a stall holds the output
//   register and the sequencer. in_if is not ready from the final word until
//   the last result is taken. reset clears the run count, the overflow flag
//   and the sequencer; the store needs no clearing, only written entries are
//   read.
// ----------------------------------------------------------------------------
`default_nettype none

module shell_sort_u16_core import ssu16_pkg::*; #(
  parameter int unsigned MAX_ITEMS = MaxItemsDef
) (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  ssu16_in_if.sink      in_if,
  ssu16_out_if.source   out_if
);

  localparam int unsigned AW = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;

  mem_ctl_t         mem_ctl;
  out_ctl_t         out_ctl;
  logic [AW-1:0]    rd_addr_a;
  logic [AW-1:0]    rd_addr_b;
  logic [AW-1:0]    wr_addr;
  logic [DataW-1:0] wr_data;
  logic [DataW-1:0] rd_data_a;
  logic [DataW-1:0] rd_data_b;
  logic             in_ready;
  logic             out_fire;
  logic             in_fire;

  // result register, valid is control state
  logic             out_valid_q, out_valid_d;
  logic [DataW-1:0] sorted_q;
  logic             eor_q;
  logic             ovf_q;

  ssu16_ctrl #(
    .MAX_ITEMS(MAX_ITEMS)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_if.valid),
    .in_value_i  (in_if.value),
    .in_final_i  (in_if.is_final),
    .in_ready_o  (in_ready),
    .rd_data_a_i (rd_data_a),
    .rd_data_b_i (rd_data_b),
    .mem_o       (mem_ctl),
    .rd_addr_a_o (rd_addr_a),
    .rd_addr_b_o (rd_addr_b),
    .wr_addr_o   (wr_addr),
    .wr_data_o   (wr_data),
    .out_o       (out_ctl),
    .out_done_i  (out_fire)
  );

  ssu16_mem #(
    .MAX_ITEMS(MAX_ITEMS)
  ) u_mem (
    .clk_i       (clk_i),
    .ctl_i       (mem_ctl),
    .rd_addr_a_i (rd_addr_a),
    .rd_addr_b_i (rd_addr_b),
    .wr_addr_i   (wr_addr),
    .wr_data_i   (wr_data),
    .rd_data_a_o (rd_data_a),
    .rd_data_b_o (rd_data_b)
  );

  assign in_if.ready = in_ready;
  assign in_fire     = in_if.valid && in_ready;
  assign out_fire    = out_valid_q && out_if.ready;

  // load on the cycle after the store read, drop on handshake
  always_comb begin
    out_valid_d = out_valid_q;
    if (out_ctl.load) begin
      out_valid_d = 1'b1;
    end else if (out_fire) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_ctl.load) begin
      sorted_q <= rd_data_a;
      eor_q    <= out_ctl.last;
      ovf_q    <= out_ctl.ovf;
    end
  end

  assign out_if.valid        = out_valid_q;
  assign out_if.sorted_value = sorted_q;
  assign out_if.end_of_run   = eor_q;
  assign out_if.overflow     = ovf_q;

  // no new run word while a result is pending
  a_no_load_during_output: assert property (
    @(posedge clk_i) disable iff (!rst_ni) in_fire |-> !out_valid_q
  ) else $error("input word accepted while a result is pending");

  // single write port: never a read and a write of the store together
  a_mem_port_exclusive: assert property (
    @(posedge clk_i) disable iff (!rst_ni) !(mem_ctl.rd_en && mem_ctl.wr_en)
  ) else $error("store read and write in the same cycle");

  // the last result of a run hands the block back to the input side
  a_run_end_reopens: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
      (out_fire && out_if.end_of_run) |=> in_ready
  ) else $error("input not ready after the end of a run");

  // a new result is only loaded into an empty output register
  a_load_into_empty: assert property (
    @(posedge clk_i) disable iff (!rst_ni) out_ctl.load |-> !out_valid_q
  ) else $error("result register overwritten before handshake");

endmodule

`default_nettype wire

// File: sv/ssu16_mem.sv
// ----------------------------------------------------------------------------
// ssu16_mem
// element store: one write port, two read ports with registered data
// ----------------------------------------------------------------------------
`default_nettype none

module ssu16_mem import ssu16_pkg::*; #(
  parameter int unsigned MAX_ITEMS = MaxItemsDef,
  localparam int unsigned AW = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1
) (
  input  wire logic             clk_i,
  input  wire mem_ctl_t         ctl_i,
  input  wire logic [AW-1:0]    rd_addr_a_i,
  input  wire logic [AW-1:0]    rd_addr_b_i,
  input  wire logic [AW-1:0]    wr_addr_i,
  input  wire logic [DataW-1:0] wr_data_i,
  output logic      [DataW-1:0] rd_data_a_o,
  output logic      [DataW-1:0] rd_data_b_o
);

  logic [DataW-1:0] mem_q [MAX_ITEMS];
  logic [DataW-1:0] rd_data_a_q;
  logic [DataW-1:0] rd_data_b_q;

  always_ff @(posedge clk_i) begin
    if (ctl_i.wr_en) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  // read data holds until the next read
  always_ff @(posedge clk_i) begin
    if (ctl_i.rd_en) begin
      rd_data_a_q <= mem_q[rd_addr_a_i];
      rd_data_b_q <= mem_q[rd_addr_b_i];
    end
  end

  assign rd_data_a_o = rd_data_a_q;
  assign rd_data_b_o = rd_data_b_q;

endmodule

`default_nettype wire

// File: sv/ssu16_ctrl.sv
// ----------------------------------------------------------------------------
// ssu16_ctrl
// load, gapped insertion sort and read-out sequencer over the element store
// ----------------------------------------------------------------------------
`default_nettype none

module ssu16_ctrl import ssu16_pkg::*; #(
  parameter int unsigned MAX_ITEMS = MaxItemsDef,
  localparam int unsigned AW = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1,
  localparam int unsigned CW = $clog2(MAX_ITEMS + 1)
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             in_valid_i,
  input  wire logic [DataW-1:0] in_value_i,
  input  wire logic             in_final_i,
  output logic                  in_ready_o,
  input  wire logic [DataW-1:0] rd_data_a_i,
  input  wire logic [DataW-1:0] rd_data_b_i,
  output mem_ctl_t              mem_o,
  output logic      [AW-1:0]    rd_addr_a_o,
  output logic      [AW-1:0]    rd_addr_b_o,
  output logic      [AW-1:0]    wr_addr_o,
  output logic      [DataW-1:0] wr_data_o,
  output out_ctl_t              out_o,
  input  wire logic             out_done_i
);

  typedef enum logic [8:0] {
    S_LOAD  = 9'b000000001,
    S_READ  = 9'b000000010,
    S_CMP   = 9'b000000100,
    S_WLO   = 9'b000001000,
    S_WHI   = 9'b000010000,
    S_ORD   = 9'b000100000,
    S_OLD   = 9'b001000000,
    S_OHOLD = 9'b010000000,
    S_IDLE2 = 9'b100000000
  } ssu16_state_e;

  ssu16_state_e state_q, state_d;
  logic [CW-1:0] count_q, count_d;
  logic          drop_q, drop_d;
  logic [AW-1:0] gap_q, gap_d;
  logic [AW-1:0] outer_q, outer_d;
  logic [AW-1:0] lo_q, lo_d;
  logic [AW-1:0] k_q, k_d;

  logic          has_room;
  logic [CW-1:0] n_new;
  logic [AW-1:0] hi_addr;
  logic [CW-1:0] outer_inc;
  logic          outer_more;
  logic [AW-1:0] gap_half;
  logic          k_last;

  assign has_room   = count_q < CW'(MAX_ITEMS);
  assign n_new      = has_room ? count_q + CW'(1) : count_q;
  assign hi_addr    = lo_q + gap_q;
  assign outer_inc  = CW'(outer_q) + CW'(1);
  assign outer_more = ((CW+1)'(outer_inc) + (CW+1)'(gap_q)) < (CW+1)'(count_q);
  assign gap_half   = gap_q >> 1;
  assign k_last     = (CW'(k_q) + CW'(1)) == count_q;

  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    drop_d      = drop_q;
    gap_d       = gap_q;
    outer_d     = outer_q;
    lo_d        = lo_q;
    k_d         = k_q;
    in_ready_o  = 1'b0;
    mem_o       = '0;
    rd_addr_a_o = lo_q;
    rd_addr_b_o = hi_addr;
    wr_addr_o   = lo_q;
    wr_data_o   = rd_data_b_i;
    out_o       = '0;

    unique case (state_q)
      S_LOAD: begin
        in_ready_o = 1'b1;
        wr_addr_o  = count_q[AW-1:0];
        wr_data_o  = in_value_i;
        if (in_valid_i) begin
          mem_o.wr_en = has_room;
          count_d     = n_new;
          if (!has_room) begin
            drop_d = 1'b1;
          end
          if (in_final_i) begin
            gap_d   = AW'(n_new >> 1);
            outer_d = '0;
            lo_d    = '0;
            k_d     = '0;
            state_d = ((n_new >> 1) == '0) ? S_ORD : S_READ;
          end
        end
      end
      S_READ: begin
        mem_o.rd_en = 1'b1;
        state_d     = S_CMP;
      end
      S_CMP, S_WHI: begin
        if (state_q == S_WHI) begin
          mem_o.wr_en = 1'b1;
          wr_addr_o   = hi_addr;
          wr_data_o   = rd_data_a_i;
        end
        if ((state_q == S_CMP) && (rd_data_a_i > rd_data_b_i)) begin
          state_d = S_WLO;
        end else if ((state_q == S_WHI) && (lo_q >= gap_q)) begin
          // keep sinking the element down the gap chain
          lo_d    = lo_q - gap_q;
          state_d = S_READ;
        end else if (outer_more) begin
          outer_d = outer_inc[AW-1:0];
          lo_d    = outer_inc[AW-1:0];
          state_d = S_READ;
        end else begin
          gap_d   = gap_half;
          outer_d = '0;
          lo_d    = '0;
          state_d = (gap_half == '0) ? S_ORD : S_READ;
        end
      end
      S_WLO: begin
        mem_o.wr_en = 1'b1;
        state_d     = S_WHI;
      end
      S_ORD: begin
        mem_o.rd_en = 1'b1;
        rd_addr_a_o = k_q;
        state_d     = S_OLD;
      end
      S_OLD: begin
        out_o.load = 1'b1;
        out_o.last = k_last;
        out_o.ovf  = drop_q;
        state_d    = S_OHOLD;
      end
      S_OHOLD: begin
        if (out_done_i) begin
          if (k_last) begin
            count_d = '0;
            drop_d  = 1'b0;
            state_d = S_LOAD;
          end else begin
            k_d     = k_q + AW'(1);
            state_d = S_ORD;
          end
        end
      end
      default: begin
        state_d = S_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_LOAD;
      count_q <= '0;
      drop_q  <= 1'b0;
      gap_q   <= '0;
      outer_q <= '0;
      lo_q    <= '0;
      k_q     <= '0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      drop_q  <= drop_d;
      gap_q   <= gap_d;
      outer_q <= outer_d;
      lo_q    <= lo_d;
      k_q     <= k_d;
    end
  end

endmodule

`default_nettype wire
